[hw/rtl/padt_pkg.sv]
package padt_pkg;

  // Table geometry
  localparam int unsigned SlotsDef = 8;

  // Field and port widths
  localparam int unsigned SeqW     = 16;
  localparam int unsigned AgeW     = 8;
  localparam int unsigned UnitsW   = 8;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned OutUserW = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  // Register reset values and limits
  localparam logic [AgeW-1:0] WindowRst = 8'd120;
  localparam logic [AgeW-1:0] SpinupRst = 8'd20;
  localparam logic [AgeW-1:0] AgeMax    = 8'd255;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegAckWindow = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSpinup    = 1'b1;

  typedef enum logic [InUserW-1:0] {
    CMD_TICK  = 2'd0,
    CMD_EVENT = 2'd1,
    CMD_ACK   = 2'd2
  } cmd_e;

  // Command code that the block drops without a result
  localparam logic [InUserW-1:0] CmdUnused = 2'd3;

  typedef enum logic [OutUserW-1:0] {
    KIND_TICK   = 3'd0,
    KIND_EVENT  = 3'd1,
    KIND_TAP    = 3'd2,
    KIND_LATE   = 3'd3,
    KIND_SILENT = 3'd4,
    KIND_MISS   = 3'd5
  } kind_e;

  // One table entry as held in the slot memory
  typedef struct packed {
    logic [SeqW-1:0] seq;
    logic            remote;
    logic [AgeW-1:0] age;
  } slot_t;

endpackage

[hw/rtl/pending_ack_deadline_table_unit.sv]
// Pending-acknowledgement table: each input word is a command (tuser) that ages the table
// (tick), registers a new event under the next 16-bit sequence number (filling the first free
// slot or evicting the oldest one), or retires an acknowledged sequence number and sizes a
// haptic tap from the time left in the window after motor spin-up. Every tick, event and ack
// gives exactly one output word; command code 3 is dropped with no output. The block takes one
// command at a time: a single slot-memory read port and one age/compare unit walk the slots in
// order, one slot per cycle. A tick or an unmatched ack walks every slot, an event walks every
// slot and then writes the chosen one, and a matched ack stops at the matching slot. The next
// command is accepted as soon as the result sits in the output register. Configuration writes
// (window, spin-up) must only be issued while the block is idle.
module pending_ack_deadline_table_unit #(
  parameter int unsigned SLOTS = padt_pkg::SlotsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Command words
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [padt_pkg::InDataW-1:0]   s_axis_tdata_i,   // remote, ack_seq[15:0], ack_silent
  input  logic [padt_pkg::InUserW-1:0]   s_axis_tuser_i,   // command
  // Result words
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [padt_pkg::OutDataW-1:0]  m_axis_tdata_o,   // seq_out[15:0], evicted,
                                                           // tap_remote, tap_units[7:0]
  output logic [padt_pkg::OutUserW-1:0]  m_axis_tuser_o,   // result_kind
  // Configuration writes
  input  logic                           cfg_we_i,
  input  logic [padt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [padt_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam int unsigned SeqW = padt_pkg::SeqW;
  localparam int unsigned AgeW = padt_pkg::AgeW;
  localparam int unsigned RemW = AgeW + 2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_EVWR = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  // Control state
  state_e                    state_q, state_d;
  logic [SLOTS-1:0]          valid_q, valid_d;
  logic [SeqW-1:0]           next_seq_q, next_seq_d;
  logic [CntW-1:0]           rd_q, rd_d;
  logic                      pv_q, pv_d;
  logic [IdxW-1:0]           pidx_q, pidx_d;
  logic                      free_q, free_d;
  logic [IdxW-1:0]           sel_q, sel_d;
  logic [IdxW-1:0]           old_idx_q, old_idx_d;
  logic [AgeW-1:0]           old_age_q, old_age_d;
  logic [AgeW-1:0]           window_q;
  logic [AgeW-1:0]           spinup_q;
  logic                      m_tvalid_q, m_tvalid_d;

  // Latched command word
  padt_pkg::cmd_e            cmd_q;
  logic                      remote_q;
  logic [SeqW-1:0]           aseq_q;
  logic                      silent_q;

  // Pending result and output register
  padt_pkg::kind_e           res_kind_q, res_kind_d;
  logic [SeqW-1:0]           res_seq_q, res_seq_d;
  logic                      res_ev_q, res_ev_d;
  logic                      res_rem_q, res_rem_d;
  logic [padt_pkg::UnitsW-1:0] res_units_q, res_units_d;
  logic [padt_pkg::OutDataW-1:0] m_tdata_q;
  logic [padt_pkg::OutUserW-1:0] m_tuser_q;

  // Slot memory
  padt_pkg::slot_t           slot_mem [SLOTS];
  padt_pkg::slot_t           ent_q;
  logic                      rd_en;
  logic [IdxW-1:0]           rd_addr;
  logic                      wr_en;
  logic [IdxW-1:0]           wr_addr;
  padt_pkg::slot_t           wr_data;

  // Shared age and budget unit
  logic [AgeW-1:0]           age_inc;
  logic signed [RemW-1:0]    remaining;
  logic [padt_pkg::UnitsW-1:0] units;

  logic                      in_acc;
  logic                      last_slot;
  logic                      emit_go;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign last_slot       = (pidx_q == IdxW'(SLOTS - 1));
  assign emit_go         = (state_q == ST_EMIT) && (!m_tvalid_q || m_axis_tready_i);

  assign age_inc   = (ent_q.age == padt_pkg::AgeMax) ? padt_pkg::AgeMax : ent_q.age + 8'd1;
  assign remaining = $signed({2'b00, window_q}) - $signed({2'b00, ent_q.age})
                   - $signed({2'b00, spinup_q});
  assign units     = (remaining[RemW-1:2] == '0) ? 8'd1 : remaining[RemW-1:2];

  // Sequencer
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    next_seq_d  = next_seq_q;
    rd_d        = rd_q;
    pv_d        = 1'b0;
    pidx_d      = pidx_q;
    free_d      = free_q;
    sel_d       = sel_q;
    old_idx_d   = old_idx_q;
    old_age_d   = old_age_q;
    res_kind_d  = res_kind_q;
    res_seq_d   = res_seq_q;
    res_ev_d    = res_ev_q;
    res_rem_d   = res_rem_q;
    res_units_d = res_units_q;
    rd_en       = 1'b0;
    rd_addr     = rd_q[IdxW-1:0];
    wr_en       = 1'b0;
    wr_addr     = pidx_q;
    wr_data     = ent_q;

    unique case (state_q)
      ST_IDLE: begin
        // Start a scan; drop the unused command code
        if (in_acc && (s_axis_tuser_i == padt_pkg::CMD_TICK
                       || s_axis_tuser_i == padt_pkg::CMD_EVENT
                       || s_axis_tuser_i == padt_pkg::CMD_ACK)) begin
          state_d   = ST_SCAN;
          rd_d      = '0;
          free_d    = 1'b0;
          old_idx_d = '0;
          old_age_d = '0;
        end
      end

      ST_SCAN: begin
        // Issue the read of the next slot
        if (rd_q < CntW'(SLOTS)) begin
          rd_en  = 1'b1;
          rd_d   = rd_q + 1'b1;
          pv_d   = 1'b1;
          pidx_d = rd_q[IdxW-1:0];
        end
        // Work on the slot read in the previous cycle
        if (pv_q) begin
          unique case (cmd_q)
            padt_pkg::CMD_TICK: begin
              if (valid_q[pidx_q]) begin
                wr_en       = 1'b1;
                wr_data.age = age_inc;
                if (age_inc >= window_q) valid_d[pidx_q] = 1'b0;
              end
              if (last_slot) begin
                state_d     = ST_EMIT;
                res_kind_d  = padt_pkg::KIND_TICK;
                res_seq_d   = '0;
                res_ev_d    = 1'b0;
                res_rem_d   = 1'b0;
                res_units_d = '0;
              end
            end
            padt_pkg::CMD_EVENT: begin
              if (!free_q) begin
                if (!valid_q[pidx_q]) begin
                  free_d = 1'b1;
                  sel_d  = pidx_q;
                end else if (ent_q.age > old_age_q) begin
                  old_idx_d = pidx_q;
                  old_age_d = ent_q.age;
                end
              end
              if (last_slot) state_d = ST_EVWR;
            end
            padt_pkg::CMD_ACK: begin
              res_seq_d   = '0;
              res_ev_d    = 1'b0;
              res_rem_d   = 1'b0;
              res_units_d = '0;
              if (valid_q[pidx_q] && ent_q.seq == aseq_q) begin
                // Retire the matching entry and size the tap
                valid_d[pidx_q] = 1'b0;
                state_d         = ST_EMIT;
                pv_d            = 1'b0;
                if (ent_q.age >= window_q) begin
                  res_kind_d = padt_pkg::KIND_MISS;
                end else if (silent_q) begin
                  res_kind_d = padt_pkg::KIND_SILENT;
                end else if (remaining <= 0) begin
                  res_kind_d = padt_pkg::KIND_LATE;
                end else begin
                  res_kind_d  = padt_pkg::KIND_TAP;
                  res_rem_d   = ent_q.remote;
                  res_units_d = units;
                end
              end else if (last_slot) begin
                state_d    = ST_EMIT;
                res_kind_d = padt_pkg::KIND_MISS;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_EVWR: begin
        // Fill the first free slot, else evict the oldest
        wr_en          = 1'b1;
        wr_addr        = free_q ? sel_q : old_idx_q;
        wr_data.seq    = next_seq_q;
        wr_data.remote = remote_q;
        wr_data.age    = '0;
        valid_d[wr_addr] = 1'b1;
        next_seq_d     = next_seq_q + 1'b1;
        res_kind_d     = padt_pkg::KIND_EVENT;
        res_seq_d      = next_seq_q;
        res_ev_d       = !free_q;
        res_rem_d      = 1'b0;
        res_units_d    = '0;
        state_d        = ST_EMIT;
      end

      ST_EMIT: begin
        // Hand the result over once the output register is free
        if (emit_go) state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    m_tvalid_d = m_tvalid_q && !m_axis_tready_i;
    if (emit_go) m_tvalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= '0;
      next_seq_q <= '0;
      rd_q       <= '0;
      pv_q       <= 1'b0;
      free_q     <= 1'b0;
      window_q   <= padt_pkg::WindowRst;
      spinup_q   <= padt_pkg::SpinupRst;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      next_seq_q <= next_seq_d;
      rd_q       <= rd_d;
      pv_q       <= pv_d;
      free_q     <= free_d;
      m_tvalid_q <= m_tvalid_d;
      // Take configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          padt_pkg::RegAckWindow: window_q <= cfg_data_i;
          padt_pkg::RegSpinup:    spinup_q <= cfg_data_i;
          default:                ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pidx_q      <= pidx_d;
    sel_q       <= sel_d;
    old_idx_q   <= old_idx_d;
    old_age_q   <= old_age_d;
    res_kind_q  <= res_kind_d;
    res_seq_q   <= res_seq_d;
    res_ev_q    <= res_ev_d;
    res_rem_q   <= res_rem_d;
    res_units_q <= res_units_d;
    if (in_acc) begin
      cmd_q    <= padt_pkg::cmd_e'(s_axis_tuser_i);
      remote_q <= s_axis_tdata_i[0];
      aseq_q   <= s_axis_tdata_i[SeqW:1];
      silent_q <= s_axis_tdata_i[SeqW+1];
    end
    if (emit_go) begin
      m_tuser_q <= res_kind_q;
      m_tdata_q <= {6'd0, res_units_q, res_rem_q, res_ev_q, res_seq_q};
    end
  end

  // Slot memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) slot_mem[wr_addr] <= wr_data;
    if (rd_en) ent_q <= slot_mem[rd_addr];
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tuser_o  = m_tuser_q;

  // Checks
  a_pv_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> state_q == ST_SCAN)
    else $error("slot in flight outside a scan");

  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_q <= CntW'(SLOTS))
    else $error("read counter past the table");

  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser_i != padt_pkg::CmdUnused) |=> state_q == ST_SCAN)
    else $error("accepted command did not start a scan");

  a_no_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && m_tuser_q != padt_pkg::KIND_TAP) |-> m_tdata_q[25:18] == '0)
    else $error("tap length on a result without a tap");

  a_tap_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && m_tuser_q == padt_pkg::KIND_TAP) |-> m_tdata_q[25:18] != '0)
    else $error("tap with zero length");

endmodule

[tb/sv/pending_ack_deadline_table_unit_tb.sv]
`timescale 1ns / 100ps

module pending_ack_deadline_table_unit_tb;

  localparam int unsigned Slots        = padt_pkg::SlotsDef;
  localparam int unsigned SeqW         = padt_pkg::SeqW;
  localparam int unsigned AgeW         = padt_pkg::AgeW;
  localparam int unsigned UnitsW       = padt_pkg::UnitsW;
  localparam int          ClkHalf      = 5;
  localparam int          SettleCycles = 2 * (Slots + 3) + 10;
  localparam int          LongHold     = 300;
  localparam int          MaxReports   = 10;
  localparam int          RecentDepth  = 12;
  localparam longint      TimeoutNs    = 64'd50_000_000;

  // One command word as seen on the input side
  typedef struct packed {
    logic [padt_pkg::InUserW-1:0] cmd;
    logic                         remote;
    logic [SeqW-1:0]              ack_seq;
    logic                         ack_silent;
  } cmd_word_t;

  // One result word as seen on the output side
  typedef struct packed {
    padt_pkg::kind_e   kind;
    logic [SeqW-1:0]   seq;
    logic              evicted;
    logic              tap_remote;
    logic [UnitsW-1:0] units;
  } outcome_t;

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [padt_pkg::InDataW-1:0]   s_axis_tdata_i  = '0;
  logic [padt_pkg::InUserW-1:0]   s_axis_tuser_i  = '0;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  logic [padt_pkg::OutDataW-1:0]  m_axis_tdata_o;
  logic [padt_pkg::OutUserW-1:0]  m_axis_tuser_o;
  logic                           cfg_we_i        = 1'b0;
  logic [padt_pkg::CfgIdxW-1:0]   cfg_idx_i       = padt_pkg::RegAckWindow;
  logic [padt_pkg::CfgDataW-1:0]  cfg_data_i      = '0;

  // Shadow of the pending table and its settings
  logic                tbl_live   [Slots];
  logic [SeqW-1:0]     tbl_seq    [Slots];
  logic                tbl_remote [Slots];
  logic [AgeW-1:0]     tbl_age    [Slots];
  logic [SeqW-1:0]     seq_next  = '0;
  logic [AgeW-1:0]     window_ms = padt_pkg::WindowRst;
  logic [AgeW-1:0]     spinup_ms = padt_pkg::SpinupRst;

  cmd_word_t           cmd_backlog [$];
  outcome_t            expected_outcomes [$];
  logic [SeqW-1:0]     recent_seqs [$];
  logic [SeqW-1:0]     gen_seq = '0;

  // Driver and receiver control
  cmd_word_t           cmd_word    = '0;
  logic                cmd_valid   = 1'b0;
  logic                cmd_taken   = 1'b0;
  int                  cmd_gap     = 0;
  bit                  cmd_idle_en = 1'b0;
  int                  res_gap     = 0;
  bit                  res_idle_en = 1'b0;
  bit                  hold_armed  = 1'b0;
  bit                  hold_used   = 1'b0;
  int                  hold_left   = 0;

  // Bookkeeping
  int                  mismatches   = 0;
  int                  cmds_taken   = 0;
  int                  unused_taken = 0;
  int                  words_seen   = 0;
  int                  evictions    = 0;
  int                  reg_writes   = 0;
  int                  kind_count [6];

  pending_ack_deadline_table_unit #(
    .SLOTS(Slots)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #ClkHalf clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < Slots; i++) begin
      tbl_live[i]   = 1'b0;
      tbl_seq[i]    = '0;
      tbl_remote[i] = 1'b0;
      tbl_age[i]    = '0;
    end
  end

  // Apply one accepted command to the shadow table and queue the word it yields
  task automatic advance_table(input cmd_word_t w);
    outcome_t o;
    int       hit;
    int       oldest;
    int       remaining;
    int       units;
    o      = '0;
    hit    = -1;
    oldest = 0;
    case (w.cmd)
      padt_pkg::CMD_TICK: begin
        o.kind = padt_pkg::KIND_TICK;
        for (int i = 0; i < Slots; i++) begin
          if (tbl_live[i]) begin
            if (tbl_age[i] != padt_pkg::AgeMax) tbl_age[i]++;
            if (tbl_age[i] >= window_ms) tbl_live[i] = 1'b0;
          end
        end
        expected_outcomes.push_back(o);
      end
      padt_pkg::CMD_EVENT: begin
        o.kind = padt_pkg::KIND_EVENT;
        o.seq  = seq_next;
        seq_next++;
        // first free slot, else the oldest live one (lowest index on a tie)
        for (int i = 0; i < Slots; i++) begin
          if (hit < 0) begin
            if (!tbl_live[i]) hit = i;
            else if (tbl_age[i] > tbl_age[oldest]) oldest = i;
          end
        end
        if (hit < 0) begin
          hit       = oldest;
          o.evicted = 1'b1;
        end
        tbl_live[hit]   = 1'b1;
        tbl_seq[hit]    = o.seq;
        tbl_remote[hit] = w.remote;
        tbl_age[hit]    = '0;
        expected_outcomes.push_back(o);
      end
      padt_pkg::CMD_ACK: begin
        o.kind = padt_pkg::KIND_MISS;
        for (int i = 0; i < Slots; i++) begin
          if (hit < 0 && tbl_live[i] && tbl_seq[i] == w.ack_seq) hit = i;
        end
        if (hit >= 0) begin
          tbl_live[hit] = 1'b0;
          remaining = int'(window_ms) - int'(tbl_age[hit]) - int'(spinup_ms);
          if (tbl_age[hit] >= window_ms) begin
            o.kind = padt_pkg::KIND_MISS;
          end else if (w.ack_silent) begin
            o.kind = padt_pkg::KIND_SILENT;
          end else if (remaining <= 0) begin
            o.kind = padt_pkg::KIND_LATE;
          end else begin
            units = remaining / 4;
            if (units < 1) units = 1;
            else if (units > 255) units = 255;
            o.kind       = padt_pkg::KIND_TAP;
            o.tap_remote = tbl_remote[hit];
            o.units      = units[UnitsW-1:0];
          end
        end
        expected_outcomes.push_back(o);
      end
      default: begin
        // unused code: dropped, nothing changes
      end
    endcase
  endtask

  // Record an accepted command word and predict its result
  always @(posedge clk_i) begin : take_cmd
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      advance_table(cmd_word);
      cmd_taken = 1'b1;
      cmds_taken++;
      if (cmd_word.cmd == padt_pkg::CmdUnused) unused_taken++;
    end
  end

  // Present command words from the backlog, with random idle bursts
  always @(negedge clk_i) begin : drive_cmd
    logic      nxt_valid;
    cmd_word_t nxt_word;
    nxt_valid = cmd_valid;
    nxt_word  = cmd_word;
    if (rst_ni) begin
      if (cmd_taken) begin
        nxt_valid = 1'b0;
        cmd_taken = 1'b0;
      end
      if (!nxt_valid) begin
        if (cmd_gap > 0) begin
          cmd_gap--;
        end else if (cmd_backlog.size() > 0) begin
          if (cmd_idle_en && $urandom_range(0, 5) == 0) begin
            cmd_gap = $urandom_range(0, 8);
          end else begin
            nxt_word  = cmd_backlog.pop_front();
            nxt_valid = 1'b1;
          end
        end
      end
    end
    cmd_valid = nxt_valid;
    cmd_word  = nxt_word;
    s_axis_tvalid_i <= nxt_valid;
    s_axis_tdata_i  <= {{(padt_pkg::InDataW - SeqW - 2){1'b0}}, nxt_word.ack_silent,
                        nxt_word.ack_seq, nxt_word.remote};
    s_axis_tuser_i  <= nxt_word.cmd;
  end

  // Drive the result-side ready: one long hold when armed, else random stall bursts
  always @(negedge clk_i) begin : drive_ready
    logic rdy;
    rdy = 1'b1;
    if (hold_armed && !hold_used) begin
      hold_left = LongHold;
      hold_used = 1'b1;
    end
    if (!rst_ni) begin
      rdy = 1'b0;
    end else if (hold_left > 0) begin
      rdy = 1'b0;
      hold_left--;
    end else if (res_gap > 0) begin
      rdy = 1'b0;
      res_gap--;
    end else if (res_idle_en && $urandom_range(0, 5) == 0) begin
      rdy     = 1'b0;
      res_gap = $urandom_range(0, 8);
    end
    m_axis_tready_i <= rdy;
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin : check_outcome
    outcome_t got;
    outcome_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind       = padt_pkg::kind_e'(m_axis_tuser_o);
      got.seq        = m_axis_tdata_o[SeqW-1:0];
      got.evicted    = m_axis_tdata_o[SeqW];
      got.tap_remote = m_axis_tdata_o[SeqW+1];
      got.units      = m_axis_tdata_o[SeqW+2 +: UnitsW];
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: result word with nothing pending: kind %0d data %h", $time,
                   m_axis_tuser_o, m_axis_tdata_o);
      end else begin
        want = expected_outcomes.pop_front();
        words_seen++;
        kind_count[want.kind]++;
        if (want.evicted) evictions++;
        if (got.kind !== want.kind || got.seq !== want.seq || got.evicted !== want.evicted ||
            got.tap_remote !== want.tap_remote || got.units !== want.units) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: word %0d expected kind %0d seq %0d ev %0b rem %0b units %0d,",
                     $time, words_seen, want.kind, want.seq, want.evicted, want.tap_remote,
                     want.units, " got kind %0d seq %0d ev %0b rem %0b units %0d",
                     got.kind, got.seq, got.evicted, got.tap_remote, got.units);
        end
      end
    end
  end

  // Add a command word to the backlog; track the sequence numbers events will get
  task automatic push_cmd(input logic [padt_pkg::InUserW-1:0] cmd, input logic remote,
                          input logic [SeqW-1:0] seq, input logic silent);
    cmd_word_t w;
    w.cmd        = cmd;
    w.remote     = remote;
    w.ack_seq    = seq;
    w.ack_silent = silent;
    cmd_backlog.push_back(w);
    if (cmd == padt_pkg::CMD_EVENT) begin
      recent_seqs.push_back(gen_seq);
      gen_seq++;
      if (recent_seqs.size() > RecentDepth) void'(recent_seqs.pop_front());
    end
  endtask

  // Fields a command does not use carry random noise
  task automatic push_tick();
    push_cmd(padt_pkg::CMD_TICK, 1'($urandom_range(0, 1)), SeqW'($urandom_range(0, 16'hFFFF)),
             1'($urandom_range(0, 1)));
  endtask

  task automatic push_event(input logic remote);
    push_cmd(padt_pkg::CMD_EVENT, remote, SeqW'($urandom_range(0, 16'hFFFF)),
             1'($urandom_range(0, 1)));
  endtask

  task automatic push_ack(input logic [SeqW-1:0] seq, input logic silent);
    push_cmd(padt_pkg::CMD_ACK, 1'($urandom_range(0, 1)), seq, silent);
  endtask

  // Ticks, events and acks (mostly of recently issued numbers), with stray acks and dropped codes mixed in
  task automatic queue_random_mix(input int count);
    int              pick;
    logic [SeqW-1:0] s;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 34) begin
        push_tick();
      end else if (pick < 66) begin
        push_event(1'($urandom_range(0, 1)));
      end else if (pick < 96) begin
        if (recent_seqs.size() > 0 && $urandom_range(0, 9) < 8)
          s = recent_seqs[$urandom_range(0, recent_seqs.size() - 1)];
        else
          s = SeqW'($urandom_range(0, 16'hFFFF));
        push_ack(s, $urandom_range(0, 3) == 0);
      end else begin
        push_cmd(padt_pkg::CmdUnused, 1'($urandom_range(0, 1)),
                 SeqW'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Wait until every word is sent and answered, then let the block settle
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || cmd_valid || expected_outcomes.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [padt_pkg::CfgIdxW-1:0] idx,
                           input logic [padt_pkg::CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == padt_pkg::RegAckWindow) window_ms = value;
    else spinup_ms = value;
    reg_writes++;
    @(posedge clk_i);
  endtask

  initial begin : run_phases
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    cmd_idle_en = 1'b1;
    res_idle_en = 1'b1;

    // Reset settings: empty-table ack, dropped code, a tap, silent ack, fill and evict
    push_ack(16'hFFFF, 1'b0);
    push_cmd(padt_pkg::CmdUnused, 1'b1, 16'hFFFF, 1'b1);
    push_tick();
    push_event(1'b1);                 // seq 0
    push_event(1'b0);                 // seq 1
    push_ack(16'd0, 1'b0);
    push_ack(16'd1, 1'b1);
    repeat (Slots) push_event(1'($urandom_range(0, 1)));   // seq 2..9 fill the table
    push_tick();
    push_event(1'b0);                 // seq 10 evicts on an age tie
    push_event(1'b1);                 // seq 11 evicts the next oldest
    push_ack(16'd2, 1'b0);            // evicted entry no longer matches
    wait_idle();

    // Short window: shortest tap, then a tap that comes too late
    write_reg(padt_pkg::RegAckWindow, 8'd23);
    push_ack(16'd10, 1'b0);
    repeat (3) push_tick();
    push_ack(16'd11, 1'b0);
    wait_idle();
    // Window shrunk under a live entry: the ack finds it expired
    write_reg(padt_pkg::RegAckWindow, 8'd3);
    push_ack(16'd4, 1'b0);
    wait_idle();
    // Window of zero: every live entry is expired
    write_reg(padt_pkg::RegAckWindow, 8'd0);
    push_ack(16'd5, 1'b1);
    push_event(1'b1);
    push_tick();
    wait_idle();

    // Largest budget: fresh entries acked at once give the longest taps
    write_reg(padt_pkg::RegAckWindow, 8'hFF);
    write_reg(padt_pkg::RegSpinup, 8'd0);
    push_event(1'b1);
    push_event(1'b0);
    push_ack(gen_seq - 16'd2, 1'b0);
    push_ack(gen_seq - 16'd1, 1'b0);
    wait_idle();

    // Reset settings again, random traffic with one long result-side hold
    write_reg(padt_pkg::RegAckWindow, padt_pkg::WindowRst);
    write_reg(padt_pkg::RegSpinup, padt_pkg::SpinupRst);
    cmd_idle_en = 1'b1;
    res_idle_en = 1'b1;
    hold_armed  = 1'b1;
    queue_random_mix(120);
    wait_idle();

    // Longest window: age entries to the saturation point, ack some just in time
    write_reg(padt_pkg::RegAckWindow, 8'hFF);
    write_reg(padt_pkg::RegSpinup, 8'd0);
    push_tick();
    repeat (Slots) push_event(1'($urandom_range(0, 1)));
    repeat (254) push_tick();
    for (int k = 0; k < recent_seqs.size(); k++) begin
      if (k == recent_seqs.size() - 3) push_tick();
      push_ack(recent_seqs[k], $urandom_range(0, 3) == 0);
    end
    wait_idle();

    // Shortest nonzero window with the largest spin-up
    write_reg(padt_pkg::RegAckWindow, 8'd1);
    write_reg(padt_pkg::RegSpinup, 8'hFF);
    queue_random_mix(100);
    wait_idle();

    write_reg(padt_pkg::RegAckWindow, 8'd40);
    write_reg(padt_pkg::RegSpinup, 8'd0);
    queue_random_mix(90);
    wait_idle();

    // Last stretch without any idling
    write_reg(padt_pkg::RegAckWindow, 8'd200);
    write_reg(padt_pkg::RegSpinup, 8'd10);
    cmd_idle_en = 1'b0;
    res_idle_en = 1'b0;
    queue_random_mix(120);
    wait_idle();

    $display("Checked %0d result words from %0d commands (%0d dropped codes), %0d register",
             words_seen, cmds_taken, unused_taken, reg_writes, " writes.");
    $display("Kinds: %0d tick, %0d event (%0d evicting), %0d tap, %0d late,",
             kind_count[padt_pkg::KIND_TICK], kind_count[padt_pkg::KIND_EVENT], evictions,
             kind_count[padt_pkg::KIND_TAP], kind_count[padt_pkg::KIND_LATE],
             " %0d silent, %0d miss.",
             kind_count[padt_pkg::KIND_SILENT], kind_count[padt_pkg::KIND_MISS]);
    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #TimeoutNs;
    $display("Timeout with %0d results still pending", expected_outcomes.size());
    $display("Verification failed");
    $finish;
  end

endmodule
